FILE: design/dda_pkg.sv
package dda_pkg;

   // default tile coordinate width
   localparam int COORD_BITS_DEF = 6;

   // per-segment direction and shape flags passed from setup to the stepper
   typedef struct packed {
      logic x_major;
      logic maj_up;
      logic min_up;
      logic zero_len;
   } desc_flags_type;

endpackage

FILE: design/dda_line_rasterizer.sv
// a segment's first point passes setup stages 1 and 2, the stepper state, the point
// register and the output slice; throughput: one point per cycle unless rsp_tready
// stalls; a segment gives |dmajor| points (up to 63), a zero-length one none; the
// rate is set by the single error-accumulator stepper, one major step a cycle
// reset clears all valid bits and the stepper busy flag; payload is not reset
module dda_line_rasterizer #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
   localparam int REQ_W = ((4 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // start_x, start_y, end_x, end_y
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // point_x, point_y
   output logic             rsp_tlast    // last_point
);
   import dda_pkg::*;

   localparam int CB = COORD_BITS;

   logic                 desc_valid, desc_ready;
   logic [CB-1:0]        desc_maj0, desc_min0, desc_amaj, desc_amin;
   desc_flags_type       desc_flags;
   logic                 pt_valid, pt_ready, pt_last;
   logic [CB-1:0]        pt_x, pt_y;
   logic                 out_vld_ff, out_vld_in, out_last_ff;
   logic [CB-1:0]        out_x_ff, out_y_ff;

   // segment setup pipeline
   dda_setup #(.COORD_BITS(CB)) u_setup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sx     (req_tdata[CB-1:0]),
      .in_sy     (req_tdata[2*CB-1:CB]),
      .in_ex     (req_tdata[3*CB-1:2*CB]),
      .in_ey     (req_tdata[4*CB-1:3*CB]),
      .out_valid (desc_valid),
      .out_ready (desc_ready),
      .out_maj0  (desc_maj0),
      .out_min0  (desc_min0),
      .out_amaj  (desc_amaj),
      .out_amin  (desc_amin),
      .out_flags (desc_flags)
   );

   // point stepper
   dda_step #(.COORD_BITS(CB)) u_step (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (desc_valid),
      .desc_ready (desc_ready),
      .desc_maj0  (desc_maj0),
      .desc_min0  (desc_min0),
      .desc_amaj  (desc_amaj),
      .desc_amin  (desc_amin),
      .desc_flags (desc_flags),
      .pt_valid   (pt_valid),
      .pt_ready   (pt_ready),
      .pt_x       (pt_x),
      .pt_y       (pt_y),
      .pt_last    (pt_last)
   );

   // output register slice
   assign pt_ready   = !out_vld_ff || rsp_tready;
   assign out_vld_in = pt_ready ? pt_valid : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pt_ready) begin
         out_x_ff    <= pt_x;
         out_y_ff    <= pt_y;
         out_last_ff <= pt_last;
      end
   end

   // result beat packing
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_W'({out_y_ff, out_x_ff});
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: design/dda_setup.sv
module dda_setup #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [COORD_BITS-1:0]   in_sx,
   input  logic [COORD_BITS-1:0]   in_sy,
   input  logic [COORD_BITS-1:0]   in_ex,
   input  logic [COORD_BITS-1:0]   in_ey,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [COORD_BITS-1:0]   out_maj0,
   output logic [COORD_BITS-1:0]   out_min0,
   output logic [COORD_BITS-1:0]   out_amaj,
   output logic [COORD_BITS-1:0]   out_amin,
   output dda_pkg::desc_flags_type out_flags
);
   import dda_pkg::*;

   localparam int CB = COORD_BITS;

   logic                 s1_vld_ff, s1_vld_in, s1_rdy;
   logic [CB-1:0]        s1_sx_ff, s1_sy_ff;
   logic signed [CB:0]   s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic                 s2_vld_ff, s2_vld_in, s2_rdy;
   logic [CB-1:0]        s2_maj0_ff, s2_min0_ff, s2_amaj_ff, s2_amin_ff;
   logic [CB-1:0]        s2_maj0_in, s2_min0_in, s2_amaj_in, s2_amin_in;
   desc_flags_type       s2_flags_ff, s2_flags_in;
   logic [CB:0]          neg_dx, neg_dy;
   logic [CB-1:0]        adx, ady;
   logic                 x_major;

   // stage handshakes
   assign s2_rdy   = !s2_vld_ff || out_ready;
   assign s1_rdy   = !s1_vld_ff || s2_rdy;
   assign in_ready = s1_rdy;

   // stage 1: signed deltas
   always_comb begin
      s1_dx_in  = $signed({1'b0, in_ex}) - $signed({1'b0, in_sx});
      s1_dy_in  = $signed({1'b0, in_ey}) - $signed({1'b0, in_sy});
      s1_vld_in = s1_rdy ? in_valid : s1_vld_ff;
   end

   // stage 2: magnitudes, major axis and directions
   always_comb begin
      neg_dx  = -s1_dx_ff;
      neg_dy  = -s1_dy_ff;
      adx     = s1_dx_ff[CB] ? neg_dx[CB-1:0] : s1_dx_ff[CB-1:0];
      ady     = s1_dy_ff[CB] ? neg_dy[CB-1:0] : s1_dy_ff[CB-1:0];
      x_major = adx > ady;
      s2_maj0_in           = x_major ? s1_sx_ff : s1_sy_ff;
      s2_min0_in           = x_major ? s1_sy_ff : s1_sx_ff;
      s2_amaj_in           = x_major ? adx : ady;
      s2_amin_in           = x_major ? ady : adx;
      s2_flags_in.x_major  = x_major;
      s2_flags_in.maj_up   = x_major ? !s1_dx_ff[CB] : !s1_dy_ff[CB];
      s2_flags_in.min_up   = x_major ? !s1_dy_ff[CB] : !s1_dx_ff[CB];
      s2_flags_in.zero_len = (s2_amaj_in == '0);
      s2_vld_in            = s2_rdy ? s1_vld_ff : s2_vld_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_sx_ff <= in_sx;
         s1_sy_ff <= in_sy;
         s1_dx_ff <= s1_dx_in;
         s1_dy_ff <= s1_dy_in;
      end
      if (s2_rdy) begin
         s2_maj0_ff  <= s2_maj0_in;
         s2_min0_ff  <= s2_min0_in;
         s2_amaj_ff  <= s2_amaj_in;
         s2_amin_ff  <= s2_amin_in;
         s2_flags_ff <= s2_flags_in;
      end
   end

   assign out_valid = s2_vld_ff;
   assign out_maj0  = s2_maj0_ff;
   assign out_min0  = s2_min0_ff;
   assign out_amaj  = s2_amaj_ff;
   assign out_amin  = s2_amin_ff;
   assign out_flags = s2_flags_ff;

endmodule

FILE: design/dda_step.sv
module dda_step #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    desc_valid,
   output logic                    desc_ready,
   input  logic [COORD_BITS-1:0]   desc_maj0,
   input  logic [COORD_BITS-1:0]   desc_min0,
   input  logic [COORD_BITS-1:0]   desc_amaj,
   input  logic [COORD_BITS-1:0]   desc_amin,
   input  dda_pkg::desc_flags_type desc_flags,
   output logic                    pt_valid,
   input  logic                    pt_ready,
   output logic [COORD_BITS-1:0]   pt_x,
   output logic [COORD_BITS-1:0]   pt_y,
   output logic                    pt_last
);
   import dda_pkg::*;

   localparam int CB = COORD_BITS;

   logic               busy_ff, busy_in;
   logic [CB-1:0]      maj_ff, maj_in, min_ff, min_in;
   logic [CB-1:0]      amaj_ff, amaj_in, amin_ff, amin_in;
   logic [CB-1:0]      remain_ff, remain_in;
   logic [CB+1:0]      err_ff, err_in;
   desc_flags_type     flags_ff, flags_in;
   logic               pt_vld_ff, pt_vld_in, pt_last_ff, pt_last_in;
   logic [CB-1:0]      pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic [CB+1:0]      two_amaj, err_sum, err_nxt;
   logic [CB-1:0]      maj_nxt, min_nxt;
   logic               carry, adv, last_step, load;

   // step and load control
   assign last_step  = (remain_ff == CB'(1));
   assign adv        = busy_ff && (!pt_vld_ff || pt_ready);
   assign desc_ready = !busy_ff || (adv && last_step);
   assign load       = desc_valid && desc_ready;

   // error accumulator step along the major axis
   always_comb begin
      two_amaj = {1'b0, amaj_ff, 1'b0};
      err_sum  = err_ff + {1'b0, amin_ff, 1'b0};
      carry    = (err_sum >= two_amaj);
      err_nxt  = carry ? (err_sum - two_amaj) : err_sum;
      maj_nxt  = flags_ff.maj_up ? (maj_ff + CB'(1)) : (maj_ff - CB'(1));
      if (carry) begin
         min_nxt = flags_ff.min_up ? (min_ff + CB'(1)) : (min_ff - CB'(1));
      end else begin
         min_nxt = min_ff;
      end
   end

   // next state of the stepper and the point register
   always_comb begin
      busy_in    = busy_ff;
      maj_in     = maj_ff;
      min_in     = min_ff;
      err_in     = err_ff;
      remain_in  = remain_ff;
      amaj_in    = amaj_ff;
      amin_in    = amin_ff;
      flags_in   = flags_ff;
      pt_vld_in  = pt_vld_ff && !pt_ready;
      pt_x_in    = pt_x_ff;
      pt_y_in    = pt_y_ff;
      pt_last_in = pt_last_ff;
      if (adv) begin
         maj_in     = maj_nxt;
         min_in     = min_nxt;
         err_in     = err_nxt;
         remain_in  = remain_ff - CB'(1);
         pt_vld_in  = 1'b1;
         pt_x_in    = flags_ff.x_major ? maj_nxt : min_nxt;
         pt_y_in    = flags_ff.x_major ? min_nxt : maj_nxt;
         pt_last_in = last_step;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in   = !desc_flags.zero_len;
         maj_in    = desc_maj0;
         min_in    = desc_min0;
         err_in    = {2'b00, desc_amaj};
         remain_in = desc_amaj;
         amaj_in   = desc_amaj;
         amin_in   = desc_amin;
         flags_in  = desc_flags;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         pt_vld_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         pt_vld_ff <= pt_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      maj_ff     <= maj_in;
      min_ff     <= min_in;
      err_ff     <= err_in;
      remain_ff  <= remain_in;
      amaj_ff    <= amaj_in;
      amin_ff    <= amin_in;
      flags_ff   <= flags_in;
      pt_x_ff    <= pt_x_in;
      pt_y_ff    <= pt_y_in;
      pt_last_ff <= pt_last_in;
   end

   assign pt_valid = pt_vld_ff;
   assign pt_x     = pt_x_ff;
   assign pt_y     = pt_y_ff;
   assign pt_last  = pt_last_ff;

`ifndef ASSERT_OFF
   // an active segment always has steps left
   a_remain_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (remain_ff != '0))
      else $error("stepper busy with no steps left");

   // error term stays below twice the major length
   a_err_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (err_ff < two_amaj))
      else $error("error accumulator out of range");

   // the final step frees the stepper unless a new segment loads
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (adv && last_step && !load) |=> !busy_ff)
      else $error("stepper still busy after last point");

   // a point with the last flag is only produced on the final step
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (adv && !last_step) |=> (pt_vld_ff && !pt_last_ff && busy_ff))
      else $error("last flag set before the final step");
`endif

endmodule

FILE: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = dda_pkg::COORD_BITS_DEF;
   localparam int REQ_W = ((4 * CB + 7) / 8) * 8;
   localparam int RSP_W = ((2 * CB + 7) / 8) * 8;
   localparam int COORD_MAX = (1 << CB) - 1;
   localparam int ITEMS_PER_PHASE = 115;
   localparam int HOLD_AT = 30;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT = 600000;

   typedef enum int {
      MODE_FREE,
      MODE_SRC_IDLE,
      MODE_SINK_STALL,
      MODE_BOTH
   } idle_mode_type;

   typedef enum int {
      SHAPE_ANY,
      SHAPE_SHORT,
      SHAPE_AXIS,
      SHAPE_DIAG,
      SHAPE_POINT,
      SHAPE_CORNER
   } shape_type;

   // segment as packed on req_tdata, start_x in the low bits
   typedef struct packed {
      logic [CB-1:0] end_y;
      logic [CB-1:0] end_x;
      logic [CB-1:0] start_y;
      logic [CB-1:0] start_x;
   } segment_type;

   typedef struct {
      logic [CB-1:0] x;
      logic [CB-1:0] y;
      logic          is_last;
   } raster_point_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // start_x, start_y, end_x, end_y
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // point_x, point_y
   logic             rsp_tlast;         // last_point

   segment_type      pending_segments[$];
   raster_point_type expected_points[$];
   idle_mode_type    idle_mode = MODE_FREE;
   int               segments_taken = 0;
   int               hold_left = 0;
   bit               hold_armed = 1'b1;
   int               cycle_count = 0;
   int               errors = 0;

   dda_line_rasterizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock generation
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // raster points of one segment, appended in emission order
   function automatic void rasterize_segment(segment_type seg);
      int dx;
      int dy;
      int adx;
      int ady;
      bit x_major;
      int dmaj;
      int dmin;
      int amaj;
      int maj0;
      int min0;
      int bias;
      int maj;
      int mnr;
      raster_point_type pt;
      dx = int'(seg.end_x) - int'(seg.start_x);
      dy = int'(seg.end_y) - int'(seg.start_y);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      // ties go to y as the major axis
      x_major = adx > ady;
      dmaj = x_major ? dx : dy;
      dmin = x_major ? dy : dx;
      amaj = x_major ? adx : ady;
      maj0 = x_major ? int'(seg.start_x) : int'(seg.start_y);
      min0 = x_major ? int'(seg.start_y) : int'(seg.start_x);
      // round half away from zero, zero minor delta rounds down
      bias = dmin > 0 ? amaj : -amaj;
      for (int i = 1; i <= amaj; i++) begin
         maj = dmaj > 0 ? maj0 + i : maj0 - i;
         mnr = min0 + (2 * dmin * i + bias) / (2 * amaj);
         pt.x = CB'(x_major ? maj : mnr);
         pt.y = CB'(x_major ? mnr : maj);
         pt.is_last = (i == amaj);
         expected_points.insert(expected_points.size(), pt);
      end
   endfunction

   // add one segment at the tail of the pending queue
   function automatic void enqueue_segment(segment_type seg);
      pending_segments.insert(pending_segments.size(), seg);
   endfunction

   function automatic logic [CB-1:0] clamp_coord(int v);
      if (v < 0) begin
         return '0;
      end
      if (v > COORD_MAX) begin
         return CB'(COORD_MAX);
      end
      return CB'(v);
   endfunction

   function automatic logic [CB-1:0] rand_coord();
      return CB'($urandom_range(COORD_MAX));
   endfunction

   function automatic segment_type make_segment(int sx, int sy, int ex, int ey);
      segment_type seg;
      seg.start_x = CB'(sx);
      seg.start_y = CB'(sy);
      seg.end_x = CB'(ex);
      seg.end_y = CB'(ey);
      return seg;
   endfunction

   // random segment, general lines four times in nine, else short, axis, diagonal, zero-length or corner ones
   function automatic segment_type random_segment();
      segment_type seg;
      shape_type shape;
      int pick;
      int span_x;
      int span_y;
      int len;
      bit up_x;
      bit up_y;
      pick = $urandom_range(8);
      shape = pick < 4 ? SHAPE_ANY : shape_type'(pick - 3);
      seg.start_x = rand_coord();
      seg.start_y = rand_coord();
      seg.end_x = rand_coord();
      seg.end_y = rand_coord();
      case (shape)
         SHAPE_SHORT: begin
            seg.end_x = clamp_coord(int'(seg.start_x) + int'($urandom_range(8)) - 4);
            seg.end_y = clamp_coord(int'(seg.start_y) + int'($urandom_range(8)) - 4);
         end
         SHAPE_AXIS: begin
            if ($urandom_range(1)) begin
               seg.end_x = seg.start_x;
            end else begin
               seg.end_y = seg.start_y;
            end
         end
         SHAPE_DIAG: begin
            up_x = 1'($urandom_range(1));
            up_y = 1'($urandom_range(1));
            span_x = up_x ? COORD_MAX - int'(seg.start_x) : int'(seg.start_x);
            span_y = up_y ? COORD_MAX - int'(seg.start_y) : int'(seg.start_y);
            len = $urandom_range(span_x < span_y ? span_x : span_y);
            seg.end_x = CB'(up_x ? int'(seg.start_x) + len : int'(seg.start_x) - len);
            seg.end_y = CB'(up_y ? int'(seg.start_y) + len : int'(seg.start_y) - len);
         end
         SHAPE_POINT: begin
            seg.end_x = seg.start_x;
            seg.end_y = seg.start_y;
         end
         SHAPE_CORNER: begin
            seg.start_x = $urandom_range(1) ? CB'(COORD_MAX) : '0;
            seg.start_y = $urandom_range(1) ? CB'(COORD_MAX) : '0;
            seg.end_x = $urandom_range(1) ? CB'(COORD_MAX) : '0;
            seg.end_y = $urandom_range(1) ? CB'(COORD_MAX) : '0;
         end
         default: begin
         end
      endcase
      return seg;
   endfunction

   function automatic bit sender_idles();
      case (idle_mode)
         MODE_SRC_IDLE: return $urandom_range(99) < 51;
         MODE_BOTH:     return $urandom_range(99) < 23;
         default:       return 1'b0;
      endcase
   endfunction

   function automatic bit sink_stalls();
      case (idle_mode)
         MODE_SINK_STALL: return $urandom_range(99) < 51;
         MODE_BOTH:       return $urandom_range(99) < 23;
         default:         return 1'b0;
      endcase
   endfunction

   // segment driver: predict on each accepted beat, then offer the next segment
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rasterize_segment(segment_type'(req_tdata));
            segments_taken <= segments_taken + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_segments.size() != 0 && !sender_idles()) begin
               req_tdata <= pending_segments.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off so the rasterizer backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_armed <= 1'b1;
      end else if (hold_armed && segments_taken == HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_armed <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // point monitor: compare each beat with the oldest predicted point
   always @(posedge clock) begin
      raster_point_type exp_pt;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               $error("unexpected point x=%0d y=%0d last=%0b",
                      rsp_tdata[CB-1:0], rsp_tdata[2*CB-1:CB], rsp_tlast);
               errors++;
            end else begin
               exp_pt = expected_points.pop_front();
               if (rsp_tdata[CB-1:0] !== exp_pt.x) begin
                  $error("point_x expected %0d actual %0d", exp_pt.x, rsp_tdata[CB-1:0]);
                  errors++;
               end
               if (rsp_tdata[2*CB-1:CB] !== exp_pt.y) begin
                  $error("point_y expected %0d actual %0d", exp_pt.y, rsp_tdata[2*CB-1:CB]);
                  errors++;
               end
               if (rsp_tlast !== exp_pt.is_last) begin
                  $error("last_point expected %0b actual %0b", exp_pt.is_last, rsp_tlast);
                  errors++;
               end
            end
         end
         rsp_tready <= (hold_left == 0) && !sink_stalls();
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero length at both corners
      enqueue_segment(make_segment(0, 0, 0, 0));
      enqueue_segment(make_segment(63, 63, 63, 63));
      // full diagonals, y major on the tie
      enqueue_segment(make_segment(0, 0, 63, 63));
      enqueue_segment(make_segment(63, 0, 0, 63));
      enqueue_segment(make_segment(0, 63, 63, 0));
      // horizontal and vertical, minor stays put
      enqueue_segment(make_segment(0, 5, 63, 5));
      enqueue_segment(make_segment(7, 63, 7, 0));
      enqueue_segment(make_segment(63, 0, 0, 0));
      enqueue_segment(make_segment(0, 0, 0, 63));
      // x major with rising and falling minor
      enqueue_segment(make_segment(0, 0, 63, 10));
      enqueue_segment(make_segment(0, 40, 63, 0));
      enqueue_segment(make_segment(63, 20, 0, 30));
      // y major in both directions
      enqueue_segment(make_segment(10, 0, 20, 63));
      enqueue_segment(make_segment(50, 63, 0, 0));
      // deltas one apart
      enqueue_segment(make_segment(0, 0, 62, 63));
      enqueue_segment(make_segment(0, 0, 63, 62));
      // single steps and half-way rounding
      enqueue_segment(make_segment(5, 5, 6, 5));
      enqueue_segment(make_segment(5, 5, 5, 4));
      enqueue_segment(make_segment(5, 5, 6, 6));
      enqueue_segment(make_segment(0, 0, 2, 1));
      enqueue_segment(make_segment(0, 1, 2, 0));

      for (int p = MODE_FREE; p <= MODE_BOTH; p++) begin
         idle_mode = idle_mode_type'(p);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            enqueue_segment(random_segment());
         end
         while (pending_segments.size() != 0) @(negedge clock);
      end

      while (req_tvalid || expected_points.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (expected_points.size() != 0) begin
         $error("%0d predicted points never arrived", expected_points.size());
         errors++;
      end
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
